// ----- rtl/pbd_pkg.sv -----
// shared constants and pipeline types for the point to box distance block
`timescale 1ns / 1ps

package pbd_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int GAP_W      = COORD_BITS;
  localparam int SQ_W       = 2 * GAP_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int DIST_W     = ROOT_W;
  localparam int AXES       = 3;
  localparam int IDX_W      = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_LOW_X  = 3'd0,
    REG_LOW_Y  = 3'd1,
    REG_LOW_Z  = 3'd2,
    REG_HIGH_X = 3'd3,
    REG_HIGH_Y = 3'd4,
    REG_HIGH_Z = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_lane_t;

endpackage

// ----- rtl/point_box_distance.sv -----
// top level: pipelined point to axis-aligned box distance
`timescale 1ns / 1ps

// Takes one point per clock cycle and never stalls; busy is high during reset and in the
// cycle after it. Each point gives one result, shown on the result ports with done high
// for a single cycle. The result comes from the square-root pipeline, one root bit per
// stage over 17 stages, behind four stages of gap, square and sum arithmetic. Results
// come out in input order.
module point_box_distance import pbd_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_index,
  input  logic [COORD_BITS-1:0]        wr_data,
  output logic                         done,
  output logic                         inside_res,
  output logic [DIST_W-1:0]            outside_distance,
  output logic [DIST_W-1:0]            inside_distance
);

  logic signed [COORD_BITS-1:0] box_low  [AXES];
  logic signed [COORD_BITS-1:0] box_high [AXES];

  logic signed [DIFF_W-1:0] d_lo [AXES];
  logic signed [DIFF_W-1:0] d_hi [AXES];
  logic                     s1_valid;

  logic [GAP_W-1:0] gap [AXES];
  logic [AXES-1:0]  in_bounds;
  logic             s2_valid;

  logic [SQ_W-1:0]  sq [AXES];
  logic [AXES-1:0]  s3_within;
  logic             s3_valid;

  root_lane_t       lane_in  [0:ROOT_W];
  root_lane_t       lane_out [0:ROOT_W];
  logic [ROOT_W:0]  lane_valid;
  logic [ROOT_W:0]  lane_all_in;

  logic signed [COORD_BITS-1:0] point [AXES];

  assign point[0] = point_x;
  assign point[1] = point_y;
  assign point[2] = point_z;

  // one root bit per call: bring down two radicand bits, try to subtract
  function automatic root_lane_t sqrt_step(root_lane_t a);
    root_lane_t       b;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    cur   = {a.rem[REM_W-3:0], a.rad[SUM_W-1 -: 2]};
    trial = {a.root, 2'b01};
    if (cur >= trial) begin
      b.rem  = cur - trial;
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = cur;
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    b.rad = {a.rad[SUM_W-3:0], 2'b00};
    return b;
  endfunction

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // box registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        box_low[a]  <= '0;
        box_high[a] <= '0;
      end
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LOW_X:  box_low[0]  <= wr_data;
        REG_LOW_Y:  box_low[1]  <= wr_data;
        REG_LOW_Z:  box_low[2]  <= wr_data;
        REG_HIGH_X: box_high[0] <= wr_data;
        REG_HIGH_Y: box_high[1] <= wr_data;
        REG_HIGH_Z: box_high[2] <= wr_data;
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      lane_valid <= '0;
    end else begin
      s1_valid   <= start && !busy;
      s2_valid   <= s1_valid;
      s3_valid   <= s2_valid;
      lane_valid <= {lane_valid[ROOT_W-1:0], s3_valid};
    end
  end

  // stage 1: signed gaps to both faces
  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      d_lo[a] <= DIFF_W'(point[a]) - DIFF_W'(box_low[a]);
      d_hi[a] <= DIFF_W'(point[a]) - DIFF_W'(box_high[a]);
    end
  end

  // stage 2: magnitudes, nearest face, bounds test
  always_ff @(posedge clk) begin
    logic [DIFF_W-1:0] m_lo;
    logic [DIFF_W-1:0] m_hi;
    for (int a = 0; a < AXES; a++) begin
      m_lo = d_lo[a][DIFF_W-1] ? DIFF_W'(-d_lo[a]) : DIFF_W'(d_lo[a]);
      m_hi = d_hi[a][DIFF_W-1] ? DIFF_W'(-d_hi[a]) : DIFF_W'(d_hi[a]);
      gap[a]       <= (m_lo < m_hi) ? m_lo[GAP_W-1:0] : m_hi[GAP_W-1:0];
      in_bounds[a] <= !d_lo[a][DIFF_W-1] && (d_hi[a][DIFF_W-1] || d_hi[a] == '0);
    end
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      sq[a] <= gap[a] * gap[a];
    end
    s3_within <= in_bounds;
  end

  // stage 4: sums, seeding both root lanes
  always_ff @(posedge clk) begin
    logic [SUM_W-1:0] acc_in;
    logic [SUM_W-1:0] acc_out;
    acc_in  = '0;
    acc_out = '0;
    for (int a = 0; a < AXES; a++) begin
      acc_in = acc_in + SUM_W'(sq[a]);
      if (!s3_within[a]) begin
        acc_out = acc_out + SUM_W'(sq[a]);
      end
    end
    lane_in[0]  <= '{rad: acc_in,  rem: '0, root: '0};
    lane_out[0] <= '{rad: acc_out, rem: '0, root: '0};
    lane_all_in <= {lane_all_in[ROOT_W-1:0], &s3_within};
  end

  // root pipeline
  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    always_ff @(posedge clk) begin
      lane_in[j+1]  <= sqrt_step(lane_in[j]);
      lane_out[j+1] <= sqrt_step(lane_out[j]);
    end
  end

  assign done             = lane_valid[ROOT_W];
  assign inside_res       = lane_all_in[ROOT_W];
  assign outside_distance = lane_out[ROOT_W].root;
  assign inside_distance  = lane_in[ROOT_W].root;

endmodule

// ----- tb/sv/point_box_distance_tb.sv -----
// testbench for point_box_distance: random and corner-case points against a shadow box model
`timescale 1ns / 1ps

module point_box_distance_tb;
  import pbd_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DIST_SAT = (1 << DIST_W) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int POINTS_PER_BOX = 225;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    logic              in_box;
    logic [DIST_W-1:0] out_d;
    logic [DIST_W-1:0] in_d;
  } box_result_t;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic signed [COORD_BITS-1:0] point_x = '0;
  logic signed [COORD_BITS-1:0] point_y = '0;
  logic signed [COORD_BITS-1:0] point_z = '0;
  logic                         wr_en = 1'b0;
  logic [IDX_W-1:0]             wr_index = '0;
  logic [COORD_BITS-1:0]        wr_data = '0;
  logic                         done;
  logic                         inside_res;
  logic [DIST_W-1:0]            outside_distance;
  logic [DIST_W-1:0]            inside_distance;

  point_t      point_queue[$];
  box_result_t results_due[$];
  int          box_lo[AXES];
  int          box_hi[AXES];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 1;
  int          gap_left = 0;

  point_box_distance uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .point_x          (point_x),
    .point_y          (point_y),
    .point_z          (point_z),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .done             (done),
    .inside_res       (inside_res),
    .outside_distance (outside_distance),
    .inside_distance  (inside_distance)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint floor_sqrt(longint n);
    longint lo_r;
    longint hi_r;
    longint mid;
    lo_r = 0;
    hi_r = 64'd1 << 20;
    while (lo_r < hi_r) begin
      mid = (lo_r + hi_r + 1) / 2;
      if (mid * mid <= n) lo_r = mid;
      else hi_r = mid - 1;
    end
    return (lo_r > DIST_SAT) ? DIST_SAT : lo_r;
  endfunction

  function automatic box_result_t box_distance(point_t p);
    int          coord[AXES];
    longint      gap_lo;
    longint      gap_hi;
    longint      gap;
    longint      sum_all;
    longint      sum_out;
    box_result_t r;
    coord[0] = p.x;
    coord[1] = p.y;
    coord[2] = p.z;
    sum_all = 0;
    sum_out = 0;
    r.in_box = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      gap_lo = coord[a] - box_lo[a];
      gap_hi = coord[a] - box_hi[a];
      if (gap_lo < 0) gap_lo = -gap_lo;
      if (gap_hi < 0) gap_hi = -gap_hi;
      gap = (gap_lo < gap_hi) ? gap_lo : gap_hi;
      sum_all += gap * gap;
      if (coord[a] < box_lo[a] || coord[a] > box_hi[a]) begin
        r.in_box = 1'b0;
        sum_out += gap * gap;
      end
    end
    r.out_d = DIST_W'(floor_sqrt(sum_out));
    r.in_d  = DIST_W'(floor_sqrt(sum_all));
    return r;
  endfunction

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin : driver
    point_t nxt;
    point_t cur;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cur.x = point_x;
        cur.y = point_y;
        cur.z = point_z;
        results_due.push_back(box_distance(cur));
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (point_queue.size() > 0) begin
          nxt = point_queue.pop_front();
          point_x <= nxt.x;
          point_y <= nxt.y;
          point_z <= nxt.z;
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    box_result_t want;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got in_box %0b out %0d in %0d",
                 $time, inside_res, outside_distance, inside_distance);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        if (inside_res !== want.in_box) begin
          $display("%0t: inside_res expected %0b got %0b", $time, want.in_box, inside_res);
          mismatch_count++;
        end
        if (outside_distance !== want.out_d) begin
          $display("%0t: outside_distance expected %0d got %0d",
                   $time, want.out_d, outside_distance);
          mismatch_count++;
        end
        if (inside_distance !== want.in_d) begin
          $display("%0t: inside_distance expected %0d got %0d",
                   $time, want.in_d, inside_distance);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // settled values between edges, so a beat issued at this edge is seen
  task automatic wait_idle();
    @(negedge clk);
    while (point_queue.size() != 0 || start || results_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic signed [31:0] data);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data[COORD_BITS-1:0];
    if (idx <= REG_LOW_Z) box_lo[idx] = $signed(data[COORD_BITS-1:0]);
    else if (idx <= REG_HIGH_Z) box_hi[idx - REG_HIGH_X] = $signed(data[COORD_BITS-1:0]);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_box(input int lx, input int ly, input int lz,
                         input int hx, input int hy, input int hz);
    wait_idle();
    write_reg(REG_LOW_X, lx);
    write_reg(REG_LOW_Y, ly);
    write_reg(REG_LOW_Z, lz);
    write_reg(REG_HIGH_X, hx);
    write_reg(REG_HIGH_Y, hy);
    write_reg(REG_HIGH_Z, hz);
  endtask

  task automatic add_point(input int x, input int y, input int z);
    point_t p;
    p.x = x[COORD_BITS-1:0];
    p.y = y[COORD_BITS-1:0];
    p.z = z[COORD_BITS-1:0];
    point_queue.push_back(p);
  endtask

  function automatic int clip_coord(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic int any_coord();
    return $urandom_range(0, 65535) - 32768;
  endfunction

  // mostly on or near the faces of the box or within 64 of it, the rest anywhere
  function automatic int pick_coord(int a);
    int lo_v;
    int hi_v;
    int pick;
    lo_v = (box_lo[a] < box_hi[a]) ? box_lo[a] : box_hi[a];
    hi_v = (box_lo[a] < box_hi[a]) ? box_hi[a] : box_lo[a];
    pick = $urandom_range(0, 99);
    if (pick < 40) return any_coord();
    if (pick < 60) begin
      case ($urandom_range(0, 3))
        0: return lo_v;
        1: return hi_v;
        2: return clip_coord(lo_v + $urandom_range(0, 2) - 1);
        default: return clip_coord(hi_v + $urandom_range(0, 2) - 1);
      endcase
    end
    lo_v = clip_coord(lo_v - 64);
    hi_v = clip_coord(hi_v + 64);
    return lo_v + $urandom_range(0, hi_v - lo_v);
  endfunction

  task automatic random_box(input int mode);
    int lo_v[AXES];
    int hi_v[AXES];
    int a_v;
    int b_v;
    int centre;
    int half;
    for (int a = 0; a < AXES; a++) begin
      a_v = any_coord();
      b_v = any_coord();
      case (mode)
        1: begin
          centre = any_coord();
          half = $urandom_range(0, 2048);
          a_v = clip_coord(centre - half);
          b_v = clip_coord(centre + half);
        end
        3: begin
          a_v = -32768;
          b_v = 32767;
        end
        4: b_v = a_v;
        default: ;
      endcase
      lo_v[a] = (a_v < b_v) ? a_v : b_v;
      hi_v[a] = (a_v < b_v) ? b_v : a_v;
      // inverted on some axes
      if (mode == 2 && $urandom_range(0, 1) == 1) begin
        lo_v[a] = hi_v[a];
        hi_v[a] = (a_v < b_v) ? a_v : b_v;
      end
    end
    set_box(lo_v[0], lo_v[1], lo_v[2], hi_v[0], hi_v[1], hi_v[2]);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset box is a single point at the origin
    add_point(0, 0, 0);
    add_point(256, 0, 0);

    set_box(-256, -512, -768, 256, 512, 768);
    add_point(0, 0, 0);
    add_point(-256, -512, -768);
    add_point(256, 512, 768);
    add_point(257, 0, 0);
    add_point(0, -513, 0);
    add_point(0, 0, 769);
    add_point(-32768, -32768, -32768);
    add_point(32767, 32767, 32767);
    add_point(-32768, 32767, -32768);
    add_point(32767, -32768, 32767);
    add_point(100, -200, 300);

    // writes past the last register must leave the box alone
    wait_idle();
    write_reg(REG_SPARE_LO, 32'sh7fff);
    write_reg(REG_SPARE_HI, -32768);
    add_point(0, 0, 0);

    // inverted x bounds
    set_box(1000, -512, -768, -1000, 512, 768);
    add_point(0, 0, 0);
    add_point(1000, 0, 0);
    add_point(-1000, 0, 0);
    add_point(2000, 0, 0);

    // largest gaps on every axis
    set_box(-32768, -32768, -32768, -32768, -32768, -32768);
    add_point(32767, 32767, 32767);
    add_point(-32768, -32768, -32768);

    set_box(-32768, -32768, -32768, 32767, 32767, 32767);
    add_point(32767, -32768, 0);
    add_point(0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      random_box(ph);
      for (int n = 0; n < POINTS_PER_BOX; n++) begin
        add_point(pick_coord(0), pick_coord(1), pick_coord(2));
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0t: %0d results expected, got none", $time, results_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pbd_pkg.sv
rtl/point_box_distance.sv
tb/sv/point_box_distance_tb.sv
